@@ sv/spq_pkg.sv @@
package spq_pkg;

    // Default number of entries the queue can hold.
    localparam int CAPACITY_DEFAULT = 16;

    // Field widths fixed by the interface.
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Command codes.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

    // One stored queue entry.
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] prio;
    } spq_entry_t;

    // Operation broadcast to every cell of the chain in a cycle.
    typedef struct packed {
        logic                     ins;
        logic                     rem;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } spq_op_t;

endpackage

@@ sv/spq_cell.sv @@
// One slot of the sorted chain. The cell keeps its entry, shifts back on an
// insert that lands ahead of it, shifts forward on a remove, or takes the
// new entry in the first slot that is empty or has a priority above the key.
module spq_cell (
    input  logic               clk,
    input  logic               occupied,
    input  logic               left_gt,
    input  spq_pkg::spq_entry_t left_entry,
    input  spq_pkg::spq_entry_t right_entry,
    input  spq_pkg::spq_op_t   op,
    output spq_pkg::spq_entry_t entry,
    output logic               gt
);

    spq_pkg::spq_entry_t entry_reg;
    spq_pkg::spq_entry_t entry_next;

    // Strictly greater keeps equal priorities in arrival order.
    assign gt    = occupied && ($signed(entry_reg.prio) > $signed(op.key));
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        priority if (op.ins && left_gt)
        begin
            entry_next = left_entry;
        end
        else if (op.ins && (!occupied || gt))
        begin
            entry_next.value = op.value;
            entry_next.prio  = op.key;
        end
        else if (op.rem)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

@@ sv/sorted_priority_queue_unit.sv @@
// Bounded minimum-priority queue built as a row of CAPACITY identical cells
// that hold the entries in ascending order of signed priority, the head in
// the first cell. Each input word is an insert (command 0) of item_value at
// item_priority, or a remove (command 1) of the head. Every accepted word
// yields exactly one result word carrying the removed value (0 unless a
// remove succeeded), a status (ok, underflow on a remove from an empty
// queue, overflow on an insert into a full one, in which case the entry is
// dropped), an empty flag and the entry count after the operation, the count
// taken modulo 32. Entries of equal priority leave in the order they came in.
// The queue is empty after reset. All cells compare the incoming priority
// with their own entry in parallel and each one shifts, loads or holds in the
// same cycle, so one word is taken every clock cycle; the result is held in
// an output register, and the input side keeps accepting as long as that
// register is empty or is being read out.
module sorted_priority_queue_unit #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                command,
    input  logic signed [spq_pkg::DATA_W-1:0]   item_value,
    input  logic signed [spq_pkg::DATA_W-1:0]   item_priority,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [spq_pkg::DATA_W-1:0]   removed_value,
    output logic        [spq_pkg::STATUS_W-1:0] status,
    output logic                                is_empty,
    output logic        [spq_pkg::COUNT_W-1:0]  entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Number of occupied cells; cells below this count hold valid entries.
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // Output register.
    logic                                out_valid_reg;
    logic signed [spq_pkg::DATA_W-1:0]   removed_value_reg;
    logic        [spq_pkg::STATUS_W-1:0] status_reg;
    logic                                is_empty_reg;
    logic        [spq_pkg::COUNT_W-1:0]  entry_count_reg;

    logic signed [spq_pkg::DATA_W-1:0]   removed_value_next;
    logic        [spq_pkg::STATUS_W-1:0] status_next;

    logic accept;
    logic full;
    logic empty;

    spq_pkg::spq_op_t    op;
    spq_pkg::spq_entry_t cell_entry [CAPACITY];
    logic                cell_gt    [CAPACITY];

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);

    // The operation reaches the cells only when it changes the queue; a
    // rejected insert or an empty remove leaves every cell as it is.
    always_comb
    begin
        op.ins   = accept && (command == spq_pkg::CMD_INSERT) && !full;
        op.rem   = accept && (command == spq_pkg::CMD_REMOVE) && !empty;
        op.key   = item_priority;
        op.value = item_value;
    end

    always_comb
    begin
        count_next         = count_reg;
        removed_value_next = '0;
        status_next        = spq_pkg::ST_OK;
        unique case (command)
            spq_pkg::CMD_INSERT:
            begin
                if (full)
                begin
                    status_next = spq_pkg::ST_OVERFLOW;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            spq_pkg::CMD_REMOVE:
            begin
                if (empty)
                begin
                    status_next = spq_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    count_next         = count_reg - CNT_W'(1);
                    removed_value_next = cell_entry[0].value;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // The chain: each cell sees its left neighbor for inserts and its right
    // neighbor for removes. The head has nothing ahead of it, and the last
    // cell reloads itself on a remove, which is harmless since it then lies
    // past the count.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        spq_pkg::spq_entry_t left_entry;
        spq_pkg::spq_entry_t right_entry;
        logic                left_gt;

        if (i == 0)
        begin : g_head
            assign left_entry = cell_entry[0];
            assign left_gt    = 1'b0;
        end
        else
        begin : g_body
            assign left_entry = cell_entry[i-1];
            assign left_gt    = cell_gt[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_inner
            assign right_entry = cell_entry[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .occupied    (count_reg > CNT_W'(i)),
            .left_gt     (left_gt),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .op          (op),
            .entry       (cell_entry[i]),
            .gt          (cell_gt[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            removed_value_reg <= removed_value_next;
            status_reg        <= status_next;
            is_empty_reg      <= (count_next == '0);
            entry_count_reg   <= spq_pkg::COUNT_W'(count_next);
        end
    end

    assign out_valid     = out_valid_reg;
    assign removed_value = removed_value_reg;
    assign status        = status_reg;
    assign is_empty      = is_empty_reg;
    assign entry_count   = entry_count_reg;

    // The count never runs past the number of cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    // The count moves only when a word is taken.
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("entry count changed without an accepted word");

    // An underflow result always reports an empty queue.
    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == spq_pkg::ST_UNDERFLOW) |-> is_empty_reg)
        else $error("underflow reported on a non-empty queue");

    // The two front cells stay in priority order.
    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(2)) |->
        ($signed(cell_entry[0].prio) <= $signed(cell_entry[1].prio)))
        else $error("head entries out of priority order");

endmodule
